@@ design/key_debounce_long_press_top_macros.svh @@
// Assertion helpers shared by kdlp_fsm.sv and key_debounce_long_press_top.sv.
`ifndef KEY_DEBOUNCE_LONG_PRESS_TOP_MACROS_SVH
`define KEY_DEBOUNCE_LONG_PRESS_TOP_MACROS_SVH

// Checked outside reset only.
`define KDLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked during reset as well.
`define KDLP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/kdlp_pkg.sv @@
package kdlp_pkg;

  localparam int NUM_KEYS  = 4;
  localparam int KEY_W     = 4;
  localparam int KEY_IDX_W = 2;
  localparam int CNT_W     = 10;
  localparam int DEB_W     = 8;
  localparam int KIND_W    = 3;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SHORT_MK = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LONG_MK  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REL_MK   = 3'd5;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_PRESSED  = 2'd2,
    MODE_LONG     = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE         = 3'd0,
    EV_SHORT        = 3'd1,
    EV_LONG_START   = 3'd2,
    EV_LONG_HOLD    = 3'd3,
    EV_LONG_RELEASE = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic [DEB_W-1:0]    debounce_ticks;
    logic [CNT_W-1:0]    long_ticks;
    logic [CNT_W-1:0]    repeat_ticks;
    logic [NUM_KEYS-1:0] short_key_mask;
    logic [NUM_KEYS-1:0] long_key_mask;
    logic [NUM_KEYS-1:0] release_key_mask;
  } cfg_t;

  typedef struct packed {
    event_kind_t          kind;
    logic [KEY_IDX_W-1:0] key;
  } event_t;

  typedef struct packed {
    logic                 found;
    logic [KEY_IDX_W-1:0] idx;
  } scan_t;

  // Lowest pressed key; bits at or above NUM_KEYS are ignored.
  function automatic scan_t scan_keys(input logic [KEY_W-1:0] levels);
    scan_t s;
    s.found = 1'b0;
    s.idx   = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (!levels[i]) begin
        s.found = 1'b1;
        s.idx   = KEY_IDX_W'(i);
      end
    end
    return s;
  endfunction

endpackage

@@ design/kdlp_if.sv @@
interface kdlp_key_if;
  import kdlp_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] keys_low;

  modport source (output valid, output keys_low, input ready);
  modport sink (input valid, input keys_low, output ready);
endinterface

interface kdlp_event_if;
  import kdlp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    event_kind;
  logic [KEY_IDX_W-1:0] event_key;

  modport source (output valid, output event_kind, output event_key, input ready);
  modport sink (input valid, input event_kind, input event_key, output ready);
endinterface

@@ design/kdlp_regs.sv @@
module kdlp_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kdlp_pkg::ADDR_W-1:0]  paddr,
  input  logic [kdlp_pkg::DATA_W-1:0]  pwdata,
  output logic [kdlp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output kdlp_pkg::cfg_t               cfg
);
  import kdlp_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEB_W'(2);
      cfg.long_ticks       <= CNT_W'(100);
      cfg.repeat_ticks     <= CNT_W'(50);
      cfg.short_key_mask   <= NUM_KEYS'(15);
      cfg.long_key_mask    <= NUM_KEYS'(6);
      cfg.release_key_mask <= NUM_KEYS'(0);
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEBOUNCE: cfg.debounce_ticks   <= pwdata[DEB_W-1:0];
        REG_LONG:     cfg.long_ticks       <= pwdata[CNT_W-1:0];
        REG_REPEAT:   cfg.repeat_ticks     <= pwdata[CNT_W-1:0];
        REG_SHORT_MK: cfg.short_key_mask   <= pwdata[NUM_KEYS-1:0];
        REG_LONG_MK:  cfg.long_key_mask    <= pwdata[NUM_KEYS-1:0];
        REG_REL_MK:   cfg.release_key_mask <= pwdata[NUM_KEYS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: prdata = DATA_W'(cfg.debounce_ticks);
      REG_LONG:     prdata = DATA_W'(cfg.long_ticks);
      REG_REPEAT:   prdata = DATA_W'(cfg.repeat_ticks);
      REG_SHORT_MK: prdata = DATA_W'(cfg.short_key_mask);
      REG_LONG_MK:  prdata = DATA_W'(cfg.long_key_mask);
      REG_REL_MK:   prdata = DATA_W'(cfg.release_key_mask);
      default:      prdata = '0;
    endcase
  end

endmodule

@@ design/kdlp_fsm.sv @@
`include "key_debounce_long_press_top_macros.svh"

module kdlp_fsm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [kdlp_pkg::KEY_W-1:0] keys_low,
  input  kdlp_pkg::cfg_t             cfg,
  output kdlp_pkg::event_t           ev
);
  import kdlp_pkg::*;

  mode_t                mode, mode_next;
  logic [KEY_IDX_W-1:0] held_key, held_key_next;
  logic [CNT_W-1:0]     tick_count, tick_count_next;

  scan_t            scan;
  logic             same;
  logic [CNT_W-1:0] cnt_inc;

  assign scan    = scan_keys(keys_low);
  assign same    = scan.found && (scan.idx == held_key);
  assign cnt_inc = (tick_count == COUNT_MAX) ? tick_count : tick_count + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      held_key   <= '0;
      tick_count <= '0;
    end else if (step) begin
      mode       <= mode_next;
      held_key   <= held_key_next;
      tick_count <= tick_count_next;
    end
  end

  // next state
  always_comb begin
    mode_next       = mode;
    held_key_next   = held_key;
    tick_count_next = tick_count;
    case (mode)
      MODE_IDLE: begin
        if (scan.found) begin
          held_key_next   = scan.idx;
          tick_count_next = '0;
          mode_next       = (cfg.debounce_ticks == '0) ? MODE_PRESSED : MODE_DEBOUNCE;
        end
      end
      MODE_DEBOUNCE: begin
        if (!same) begin
          mode_next = MODE_IDLE;
        end else if (cnt_inc >= CNT_W'(cfg.debounce_ticks)) begin
          tick_count_next = '0;
          mode_next       = MODE_PRESSED;
        end else begin
          tick_count_next = cnt_inc;
        end
      end
      MODE_PRESSED: begin
        if (!same) begin
          mode_next = MODE_IDLE;
        end else if (cnt_inc >= cfg.long_ticks) begin
          tick_count_next = '0;
          mode_next       = MODE_LONG;
        end else begin
          tick_count_next = cnt_inc;
        end
      end
      MODE_LONG: begin
        if (!same) begin
          mode_next = MODE_IDLE;
        end else if (cnt_inc >= cfg.repeat_ticks) begin
          tick_count_next = '0;
        end else begin
          tick_count_next = cnt_inc;
        end
      end
      default: mode_next = MODE_IDLE;
    endcase
  end

  // event output
  always_comb begin
    ev.kind = EV_NONE;
    case (mode)
      MODE_PRESSED: begin
        if (!same) begin
          if (cfg.short_key_mask[held_key]) ev.kind = EV_SHORT;
        end else if (cnt_inc >= cfg.long_ticks && cfg.long_key_mask[held_key]) begin
          ev.kind = EV_LONG_START;
        end
      end
      MODE_LONG: begin
        if (!same) begin
          if (cfg.release_key_mask[held_key]) ev.kind = EV_LONG_RELEASE;
        end else if (cnt_inc >= cfg.repeat_ticks && cfg.long_key_mask[held_key]) begin
          ev.kind = EV_LONG_HOLD;
        end
      end
      default: ev.kind = EV_NONE;
    endcase
    ev.key = (ev.kind == EV_NONE) ? '0 : held_key;
  end

  `KDLP_ASSERT(a_hold_when_idle, !step |=> $stable(mode) && $stable(tick_count) && $stable(held_key), "fsm state moved without a beat")
  `KDLP_ASSERT(a_idle_no_event, mode == MODE_IDLE |-> ev.kind == EV_NONE, "event raised from idle")
  `KDLP_ASSERT(a_long_needs_press, step && mode_next == MODE_LONG && mode != MODE_LONG |-> mode == MODE_PRESSED, "long mode entered without press")

endmodule

@@ design/key_debounce_long_press_top.sv @@
// Key debounce with long press and hold repeat.
// key_in carries one scan tick per beat: keys_low, four active-low key levels.
// event_out returns exactly one beat per tick: event_kind (0 none, 1 short,
// 2 long start, 3 long hold, 4 long release) and event_key (0 when none).
// Timing thresholds and per-key event masks sit on the APB port at 4*index;
// write them only while no tick is in flight.
// Throughput: one tick per cycle while event_out does not stall. The tick is
// registered, the key state machine and its tick counter update in one pass,
// and the event is registered again: an accepted beat passes through the input
// register and then the result register before it reaches event_out.
// When event_out stalls, the result register holds and the input register
// fills; key_in.ready drops only once both are full, and resumes in the
// cycle the sink takes the waiting beat.
// Synchronous reset clears both stages, returns the state machine to idle
// and loads the register defaults.
`include "key_debounce_long_press_top_macros.svh"

module key_debounce_long_press_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kdlp_pkg::ADDR_W-1:0] paddr,
  input  logic [kdlp_pkg::DATA_W-1:0] pwdata,
  output logic [kdlp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  kdlp_key_if.sink                    key_in,
  kdlp_event_if.source                event_out
);
  import kdlp_pkg::*;

  cfg_t   cfg;
  event_t ev;

  logic             in_valid;
  logic [KEY_W-1:0] in_keys;
  logic             res_valid;
  event_t           res_ev;
  logic             res_ready;
  logic             advance;

  assign res_ready    = !res_valid || event_out.ready;
  assign advance      = in_valid && res_ready;
  assign key_in.ready = !in_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (key_in.ready) begin
      in_valid <= key_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_in.ready && key_in.valid) begin
      in_keys <= key_in.keys_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_ev <= ev;
    end
  end

  kdlp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kdlp_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .keys_low (in_keys),
    .cfg      (cfg),
    .ev       (ev)
  );

  assign event_out.valid      = res_valid;
  assign event_out.event_kind = res_ev.kind;
  assign event_out.event_key  = res_ev.key;

  `KDLP_ASSERT_RST(a_reset_empty, rst |=> !res_valid && !in_valid, "stages not empty after reset")
  `KDLP_ASSERT(a_stall_no_advance, res_valid && !event_out.ready |-> !advance, "tick processed while result stalled")
  `KDLP_ASSERT(a_accept_fills, key_in.valid && key_in.ready |=> in_valid, "accepted beat lost")

endmodule
